// ===== sv/mqm_pkg.sv =====
// Shared types and codes for the multi-queue mailbox.
package mqm_pkg;

	// Fixed payload widths of the request and response channels.
	localparam int ID_W     = 4;
	localparam int MSG_IO_W = 32;
	localparam int STATUS_W = 3;
	localparam int WAKE_W   = 2;
	localparam int PSTATE_W = 2;

	// Operation codes.
	localparam logic OP_SEND = 1'b0;
	localparam logic OP_RECV = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 3'd0,
		ST_BAD_ID = 3'd1,
		ST_FREE  = 3'd2,
		ST_FULL  = 3'd3,
		ST_EMPTY = 3'd4
	} status_t;

	typedef enum logic [WAKE_W-1:0] {
		WAKE_NONE    = 2'd0,
		WAKE_READY   = 2'd1,
		WAKE_UNSLEEP = 2'd2
	} wake_t;

	typedef enum logic [PSTATE_W-1:0] {
		PS_FREE  = 2'd0,
		PS_WAIT  = 2'd1,
		PS_TIMED = 2'd2,
		PS_OTHER = 2'd3
	} pstate_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RDWAIT
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic capture;
		logic commit;
		logic load_out;
		logic out_from_mem;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic pop_ok;
	} sts_t;

endpackage

// ===== sv/mqm_if.sv =====
// Request and response channel interfaces of the multi-queue mailbox.
interface mqm_req_if;
	logic                         valid;
	logic                         ready;
	logic                         operation;
	logic [mqm_pkg::ID_W-1:0]     queue_id;
	logic [mqm_pkg::MSG_IO_W-1:0] message;
	logic [mqm_pkg::PSTATE_W-1:0] target_state;

	modport source (output valid, operation, queue_id, message, target_state, input ready);
	modport sink (input valid, operation, queue_id, message, target_state, output ready);
endinterface

interface mqm_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [mqm_pkg::STATUS_W-1:0] status;
	logic [mqm_pkg::MSG_IO_W-1:0] message_out;
	logic [mqm_pkg::WAKE_W-1:0]   wake_action;

	modport source (output valid, status, message_out, wake_action, input ready);
	modport sink (input valid, status, message_out, wake_action, output ready);
endinterface

// ===== sv/mqm_ctrl.sv =====
// Controller state machine of the multi-queue mailbox.
module mqm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	input  mqm_pkg::sts_t  sts,
	output mqm_pkg::cmd_t  cmd
);

	mqm_pkg::state_t state_q, state_nxt;
	logic            out_valid_q;
	logic            out_free;

	// The result register can take a new result when empty or being drained.
	assign out_free  = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mqm_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			mqm_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = mqm_pkg::S_EXEC;
				end
			end
			mqm_pkg::S_EXEC: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					if (sts.pop_ok) begin
						state_nxt = mqm_pkg::S_RDWAIT;
					end else begin
						cmd.load_out = 1'b1;
						state_nxt    = mqm_pkg::S_IDLE;
					end
				end
			end
			mqm_pkg::S_RDWAIT: begin
				if (out_free) begin
					cmd.load_out     = 1'b1;
					cmd.out_from_mem = 1'b1;
					state_nxt        = mqm_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = mqm_pkg::S_IDLE;
			end
		endcase
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// A loaded result is presented on the next cycle.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> rsp_valid)
		else $error("loaded result not presented");

	// An accepted request always moves on to execution.
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> state_q == mqm_pkg::S_EXEC)
		else $error("accepted request not executed");

	// The read wait is only entered from execution.
	a_rdwait_entry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mqm_pkg::S_RDWAIT |->
			$past(state_q) == mqm_pkg::S_EXEC || $past(state_q) == mqm_pkg::S_RDWAIT)
		else $error("read wait entered out of order");

endmodule

// ===== sv/mqm_dp.sv =====
// Datapath of the multi-queue mailbox: request registers, queue pointers,
// message store and result registers.
module mqm_dp #(
	parameter int NUM_QUEUES  = 8,
	parameter int QUEUE_DEPTH = 8,
	parameter int MSG_WIDTH   = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mqm_pkg::cmd_t                cmd,
	output mqm_pkg::sts_t                sts,
	input  logic                         operation,
	input  logic [mqm_pkg::ID_W-1:0]     queue_id,
	input  logic [mqm_pkg::MSG_IO_W-1:0] message,
	input  logic [mqm_pkg::PSTATE_W-1:0] target_state,
	output logic [mqm_pkg::STATUS_W-1:0] status,
	output logic [mqm_pkg::MSG_IO_W-1:0] message_out,
	output logic [mqm_pkg::WAKE_W-1:0]   wake_action
);

	localparam int SW        = (MSG_WIDTH < mqm_pkg::MSG_IO_W) ? MSG_WIDTH : mqm_pkg::MSG_IO_W;
	localparam int QW        = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PW        = $clog2(QUEUE_DEPTH);
	localparam int CW        = $clog2(QUEUE_DEPTH + 1);
	localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
	localparam int AW        = $clog2(MEM_DEPTH);
	localparam logic [AW-1:0] DEPTH_A = AW'(QUEUE_DEPTH);
	localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

	// Request registers.
	logic                         op_q;
	logic [mqm_pkg::ID_W-1:0]     id_q;
	logic [SW-1:0]                msg_q;
	mqm_pkg::pstate_t             pstate_q;

	// Queue state.
	logic [PW-1:0] head_q [NUM_QUEUES];
	logic [PW-1:0] tail_q [NUM_QUEUES];
	logic [CW-1:0] cnt_q  [NUM_QUEUES];

	// Message store and its read data.
	logic [SW-1:0] msg_store_q [MEM_DEPTH];
	logic [SW-1:0] rd_data_q;

	// Result registers.
	mqm_pkg::status_t             status_q;
	logic [mqm_pkg::MSG_IO_W-1:0] msg_out_q;
	mqm_pkg::wake_t               wake_q;

	logic             id_ok;
	logic [QW-1:0]    q;
	logic [PW-1:0]    head, tail, head_nxt, tail_nxt;
	logic [CW-1:0]    cnt;
	logic             push, pop;
	mqm_pkg::status_t st;
	mqm_pkg::wake_t   wake;
	logic [AW-1:0]    wr_addr, rd_addr;
	logic             wr_en, rd_en;

	// Capture the request.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= operation;
			id_q     <= queue_id;
			msg_q    <= SW'(message);
			pstate_q <= mqm_pkg::pstate_t'(target_state);
		end
	end

	// Look up the addressed queue.
	assign id_ok = 32'(id_q) < 32'(NUM_QUEUES);
	assign q     = QW'(id_q);
	assign head  = head_q[q];
	assign tail  = tail_q[q];
	assign cnt   = cnt_q[q];
	assign head_nxt = (head == PTR_LAST) ? '0 : head + 1'b1;
	assign tail_nxt = (tail == PTR_LAST) ? '0 : tail + 1'b1;

	// Decide the outcome of the request.
	always_comb begin
		st   = mqm_pkg::ST_OK;
		wake = mqm_pkg::WAKE_NONE;
		push = 1'b0;
		pop  = 1'b0;
		if (!id_ok) begin
			st = mqm_pkg::ST_BAD_ID;
		end else if (op_q == mqm_pkg::OP_SEND) begin
			if (pstate_q == mqm_pkg::PS_FREE) begin
				st = mqm_pkg::ST_FREE;
			end else if (cnt == CNT_FULL) begin
				st = mqm_pkg::ST_FULL;
			end else begin
				push = 1'b1;
				case (pstate_q)
					mqm_pkg::PS_WAIT:  wake = mqm_pkg::WAKE_READY;
					mqm_pkg::PS_TIMED: wake = mqm_pkg::WAKE_UNSLEEP;
					default:           wake = mqm_pkg::WAKE_NONE;
				endcase
			end
		end else begin
			if (cnt == '0) begin
				st = mqm_pkg::ST_EMPTY;
			end else begin
				pop = 1'b1;
			end
		end
	end

	assign sts.pop_ok = pop;

	// Pointer and occupancy update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else if (cmd.commit) begin
			if (push) begin
				tail_q[q] <= tail_nxt;
				cnt_q[q]  <= cnt + 1'b1;
			end else if (pop) begin
				head_q[q] <= head_nxt;
				cnt_q[q]  <= cnt - 1'b1;
			end
		end
	end

	// Message store: one write or one registered read per request.
	assign wr_en   = cmd.commit && push;
	assign rd_en   = cmd.commit && pop;
	assign wr_addr = AW'(q) * DEPTH_A + AW'(tail);
	assign rd_addr = AW'(q) * DEPTH_A + AW'(head);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			msg_store_q[wr_addr] <= msg_q;
		end
		if (rd_en) begin
			rd_data_q <= msg_store_q[rd_addr];
		end
	end

	// Result registers.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (cmd.out_from_mem) begin
				status_q  <= mqm_pkg::ST_OK;
				msg_out_q <= mqm_pkg::MSG_IO_W'(rd_data_q);
				wake_q    <= mqm_pkg::WAKE_NONE;
			end else begin
				status_q  <= st;
				msg_out_q <= '0;
				wake_q    <= wake;
			end
		end
	end

	assign status      = status_q;
	assign message_out = msg_out_q;
	assign wake_action = wake_q;

	// Occupancy never exceeds the queue depth.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		id_ok |-> cnt <= CNT_FULL)
		else $error("queue occupancy above depth");

	// The store is never written and read in the same cycle.
	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("store written and read together");

	// A committed send raises the occupancy of its queue by one.
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> cnt == $past(cnt) + 1'b1)
		else $error("send did not bump occupancy");

endmodule

// ===== sv/multi_queue_mailbox.sv =====
// Top level of the multi-queue mailbox: controller and datapath.
//
// Channel  Role    Payload
// req      sink    operation, queue_id, message, target_state
// rsp      source  status, message_out, wake_action
//
// One request at a time. After a request is taken, the block passes through
// the execute state, where it updates the queue, and for a successful
// receive also the read-wait state, which holds the registered read of the
// message store; the response is then registered, and the next request can
// be taken while the response still waits to be taken. Reset clears the
// queue pointers and counts at once; the message store needs no clearing. A
// stalled response holds the block before it updates any queue.
module multi_queue_mailbox #(
	parameter int NUM_QUEUES  = 8,
	parameter int QUEUE_DEPTH = 8,
	parameter int MSG_WIDTH   = 32
) (
	input logic       clk,
	input logic       arst_n,
	mqm_req_if.sink   req,
	mqm_rsp_if.source rsp
);

	mqm_pkg::cmd_t cmd;
	mqm_pkg::sts_t sts;

	// Sequencing of each request.
	mqm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Queue state, message store and response registers.
	mqm_dp #(
		.NUM_QUEUES  (NUM_QUEUES),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.MSG_WIDTH   (MSG_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.operation    (req.operation),
		.queue_id     (req.queue_id),
		.message      (req.message),
		.target_state (req.target_state),
		.status       (rsp.status),
		.message_out  (rsp.message_out),
		.wake_action  (rsp.wake_action)
	);

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the multi-queue mailbox, driven by directed and random requests.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mqm_pkg::*;

	localparam int NUM_Q        = 8;
	localparam int DEPTH        = 8;
	localparam int PTR_W        = $clog2(DEPTH);
	localparam int CNT_W        = $clog2(DEPTH + 1);
	localparam int RUN_LIMIT    = 1_000_000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		status_t             status;
		logic [MSG_IO_W-1:0] message_out;
		wake_t               wake_action;
	} reply_t;

	logic clk;
	logic arst_n;

	mqm_req_if req_ch ();
	mqm_rsp_if rsp_ch ();

	multi_queue_mailbox #(
		.NUM_QUEUES (NUM_Q),
		.QUEUE_DEPTH(DEPTH),
		.MSG_WIDTH  (32)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Shadow copy of every queue, updated as each request is taken.
	logic [MSG_IO_W-1:0] slot_mem   [NUM_Q][DEPTH];
	logic [PTR_W-1:0]    head_ptr   [NUM_Q];
	logic [PTR_W-1:0]    tail_ptr   [NUM_Q];
	logic [CNT_W-1:0]    fill_count [NUM_Q];

	reply_t pending_replies [$];

	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;
	int hold_left          = 0;
	int error_count        = 0;
	int cycle_count        = 0;

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Cycle counter with a hard limit on the run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= RUN_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
		return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
	endfunction

	// Work out the response to one request and apply it to the shadow queues.
	function automatic reply_t predict_reply(input logic op, input logic [ID_W-1:0] id,
			input logic [MSG_IO_W-1:0] msg, input pstate_t ps);
		reply_t r;
		int     q;
		r.status      = ST_OK;
		r.message_out = '0;
		r.wake_action = WAKE_NONE;
		q = id;
		if (id >= NUM_Q) begin
			r.status = ST_BAD_ID;
		end else if (op == OP_SEND) begin
			if (ps == PS_FREE) begin
				r.status = ST_FREE;
			end else if (fill_count[q] >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				slot_mem[q][tail_ptr[q]] = msg;
				tail_ptr[q]   = next_ptr(tail_ptr[q]);
				fill_count[q] = fill_count[q] + 1'b1;
				case (ps)
					PS_WAIT: begin
						r.wake_action = WAKE_READY;
					end
					PS_TIMED: begin
						r.wake_action = WAKE_UNSLEEP;
					end
					default: begin
						r.wake_action = WAKE_NONE;
					end
				endcase
			end
		end else if (fill_count[q] == 0) begin
			r.status = ST_EMPTY;
		end else begin
			r.message_out = slot_mem[q][head_ptr[q]];
			head_ptr[q]   = next_ptr(head_ptr[q]);
			fill_count[q] = fill_count[q] - 1'b1;
		end
		return r;
	endfunction

	// Offer one request after a random gap and record its expected response once taken.
	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_request(input logic op, input logic [ID_W-1:0] id,
			input logic [MSG_IO_W-1:0] msg, input pstate_t ps);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.operation    <= op;
		req_ch.queue_id     <= id;
		req_ch.message      <= msg;
		req_ch.target_state <= ps;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
		pending_replies.push_back(predict_reply(op, id, msg, ps));
		@(negedge clk);
	endtask

	// Random request, leaning toward one queue so that it fills up or runs dry.
	task automatic send_random_request(input int focus_q, input int send_pct);
		logic            op;
		logic [ID_W-1:0] id;
		pstate_t         ps;
		op = ($urandom_range(99) < send_pct) ? OP_SEND : OP_RECV;
		if ($urandom_range(9) == 0) begin
			id = ID_W'($urandom_range(15, NUM_Q));
		end else if ($urandom_range(3) != 0) begin
			id = ID_W'(focus_q);
		end else begin
			id = ID_W'($urandom_range(NUM_Q - 1));
		end
		ps = ($urandom_range(7) == 0) ? PS_FREE : pstate_t'($urandom_range(3, 1));
		send_request(op, id, $urandom(), ps);
	endtask

	// Stop offering requests until every outstanding response has come back.
	task automatic wait_for_replies();
		req_ch.valid <= 1'b0;
		while (pending_replies.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Response side: random stalls, or a long counted hold-off when one is asked for.
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	// Compare each response taken with the oldest expected one.
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_replies.size() == 0) begin
				$error("response arrived with no request outstanding");
				error_count++;
			end else begin
				want = pending_replies.pop_front();
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
					error_count++;
				end
				if (rsp_ch.message_out !== want.message_out) begin
					$error("message_out: expected %h, got %h", want.message_out,
						rsp_ch.message_out);
					error_count++;
				end
				if (rsp_ch.wake_action !== want.wake_action) begin
					$error("wake_action: expected %0d, got %0d", want.wake_action,
						rsp_ch.wake_action);
					error_count++;
				end
			end
		end
	end

	// Extremes of the fields and each error case, back to back.
	task automatic test_directed();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		// Empty queue, bad ids on both operations, and a free target.
		send_request(OP_RECV, 4'd0, 32'h0000_0000, PS_OTHER);
		send_request(OP_SEND, 4'd8, 32'h1234_5678, PS_WAIT);
		send_request(OP_RECV, 4'd15, 32'hFFFF_FFFF, PS_OTHER);
		send_request(OP_SEND, 4'd0, 32'hDEAD_BEEF, PS_FREE);
		// One send for each wake kind, then drain the queue and read it once more empty.
		send_request(OP_SEND, 4'd0, 32'hFFFF_FFFF, PS_WAIT);
		send_request(OP_SEND, 4'd0, 32'h0000_0000, PS_TIMED);
		send_request(OP_SEND, 4'd0, 32'hA5A5_5A5A, PS_OTHER);
		repeat (4) send_request(OP_RECV, 4'd0, 32'h0000_0000, PS_FREE);
		// Fill the last queue, overflow it, pop two and wrap the tail once more.
		for (int i = 0; i < DEPTH; i++) begin
			send_request(OP_SEND, ID_W'(NUM_Q - 1), 32'h0101_0101 * (i + 1), PS_OTHER);
		end
		send_request(OP_SEND, ID_W'(NUM_Q - 1), 32'hFFFF_0000, PS_WAIT);
		repeat (2) send_request(OP_RECV, ID_W'(NUM_Q - 1), 32'h0000_0000, PS_OTHER);
		send_request(OP_SEND, ID_W'(NUM_Q - 1), 32'h5A5A_A5A5, PS_TIMED);
	endtask

	// Random traffic in bursts of sixteen, each burst with its own queue and mix.
	task automatic test_random(input int count, input int idle_pct, input int stall_pct);
		int focus_q;
		int send_pct;
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		focus_q  = 0;
		send_pct = 50;
		for (int i = 0; i < count; i++) begin
			if (i % 16 == 0) begin
				focus_q  = $urandom_range(NUM_Q - 1);
				send_pct = $urandom_range(85, 15);
			end
			send_random_request(focus_q, send_pct);
		end
	endtask

	// Hold the response side off for a long stretch while requests keep coming.
	task automatic test_backpressure();
		int focus_q;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		focus_q   = $urandom_range(NUM_Q - 1);
		hold_left = HOLD_CYCLES;
		repeat (12) send_random_request(focus_q, 70);
	endtask

	// Let the block run completely dry between two groups of requests.
	task automatic test_sender_pause();
		int focus_q;
		focus_q = $urandom_range(NUM_Q - 1);
		repeat (10) send_random_request(focus_q, 60);
		wait_for_replies();
		repeat (10) send_random_request(focus_q, 40);
	endtask

	// Reset, run each test in turn, then settle and report.
	initial begin
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.operation    = OP_SEND;
		req_ch.queue_id     = '0;
		req_ch.message      = '0;
		req_ch.target_state = PS_FREE;
		for (int q = 0; q < NUM_Q; q++) begin
			head_ptr[q]   = '0;
			tail_ptr[q]   = '0;
			fill_count[q] = '0;
		end
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random(250, 0, 0);
		test_backpressure();
		test_random(250, 85, 0);
		test_sender_pause();
		test_random(250, 0, 85);
		test_random(250, 26, 26);

		wait_for_replies();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== multi_queue_mailbox.f =====
sv/mqm_pkg.sv
sv/mqm_if.sv
sv/mqm_ctrl.sv
sv/mqm_dp.sv
sv/multi_queue_mailbox.sv
sim/tb_top.sv
